### hdl/lfsc_pkg.sv
package lfsc_pkg;

  // Wheel command limit and steering correction step
  localparam int unsigned SpeedLimit = 150;
  localparam int unsigned CorrStep   = 5;

  // Depth of the command queue between front and back
  localparam int unsigned QueueDepth = 2;

  // APB address width: eight 32-bit registers
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // Motion states as they appear on the result word
  typedef enum logic [2:0] {
    MS_FORWARD = 3'd0,
    MS_LEFT    = 3'd1,
    MS_RIGHT   = 3'd2,
    MS_SEARCH  = 3'd3,
    MS_SPIN    = 3'd4,
    MS_STOP    = 3'd5
  } motion_e;

  // Motor frame direction codes
  typedef enum logic [1:0] {
    DIR_FWD  = 2'd0,
    DIR_REV  = 2'd1,
    DIR_LOST = 2'd2
  } dir_e;

  // Line side seen last by the tracker
  typedef enum logic [1:0] {
    SIDE_NONE  = 2'd0,
    SIDE_LEFT  = 2'd1,
    SIDE_RIGHT = 2'd2
  } side_e;

  // Register indexes on the APB port
  typedef enum logic [2:0] {
    REG_STRAIGHT  = 3'd0,
    REG_OUTER     = 3'd1,
    REG_CORR_MIN  = 3'd2,
    REG_CORR_MAX  = 3'd3,
    REG_SEARCH    = 3'd4,
    REG_SPIN      = 3'd5,
    REG_TIMEOUT   = 3'd6,
    REG_OBSTACLE  = 3'd7
  } reg_idx_e;

  // Configuration registers
  typedef struct packed {
    logic [7:0]  straight_speed;
    logic [7:0]  turn_outer_speed;
    logic [7:0]  correction_min;
    logic [7:0]  correction_max;
    logic [7:0]  search_slowdown;
    logic [7:0]  spin_speed;
    logic [7:0]  lost_timeout_ticks;
    logic [15:0] obstacle_echo_us;
  } cfg_t;

  // Classified command handed from front to back
  typedef struct packed {
    motion_e    motion;
    logic       search_left;
    logic       spin_phase;
    logic [7:0] run;
  } cmd_t;

endpackage

### hdl/lfsc_in_if.sv
interface lfsc_in_if;
  logic        valid;
  logic        ready;
  logic        left_black;
  logic        right_black;
  logic        echo_valid;
  logic [15:0] echo_us;

  modport source (output valid, left_black, right_black, echo_valid, echo_us, input ready);
  modport sink   (input valid, left_black, right_black, echo_valid, echo_us, output ready);
endinterface

### hdl/lfsc_out_if.sv
interface lfsc_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        motion_state;
  logic signed [8:0] left_wheel;
  logic signed [8:0] right_wheel;
  logic [1:0]        left_dir_code;
  logic [7:0]        left_magnitude;
  logic [1:0]        right_dir_code;
  logic [7:0]        right_magnitude;

  modport source (output valid, motion_state, left_wheel, right_wheel, left_dir_code,
                  left_magnitude, right_dir_code, right_magnitude, input ready);
  modport sink   (input valid, motion_state, left_wheel, right_wheel, left_dir_code,
                  left_magnitude, right_dir_code, right_magnitude, output ready);
endinterface

### hdl/lfsc_front.sv
module lfsc_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  lfsc_in_if.sink        in_s,
  input  lfsc_pkg::cfg_t cfg_i,
  input  logic           full_i,
  output logic           push_o,
  output lfsc_pkg::cmd_t cmd_o
);
  import lfsc_pkg::*;

  logic [15:0] lost_ticks_q, lost_ticks_d, lost_inc;
  logic        spin_phase_q, spin_phase_d;
  logic        search_left_q, search_left_d;
  side_e       last_side_q, last_side_d, side;
  logic [7:0]  run_q, run_d;
  logic        obstacle, lost, timed_out;
  motion_e     motion;

  // Take a word whenever the queue has room
  assign in_s.ready = ~full_i;
  assign push_o     = in_s.valid & ~full_i;

  // Classify the word
  assign obstacle  = in_s.echo_valid && (in_s.echo_us != 16'd0)
                     && (in_s.echo_us < cfg_i.obstacle_echo_us);
  assign lost      = in_s.left_black & in_s.right_black;
  assign lost_inc  = (lost_ticks_q == 16'hFFFF) ? lost_ticks_q : lost_ticks_q + 16'd1;
  assign timed_out = lost_inc >= {8'd0, cfg_i.lost_timeout_ticks};
  assign side      = in_s.left_black ? SIDE_LEFT : SIDE_RIGHT;

  // Next tracking state and motion for this word
  always_comb begin
    lost_ticks_d  = lost_ticks_q;
    spin_phase_d  = spin_phase_q;
    search_left_d = search_left_q;
    last_side_d   = last_side_q;
    run_d         = run_q;
    motion        = MS_FORWARD;
    priority if (obstacle) begin
      lost_ticks_d = 16'd0;
      spin_phase_d = 1'b0;
      motion       = MS_STOP;
    end else if (lost) begin
      if (lost_ticks_q == 16'd0) begin
        search_left_d = ~search_left_q;
      end
      lost_ticks_d = lost_inc;
      spin_phase_d = ~spin_phase_q;
      motion       = timed_out ? MS_SPIN : MS_SEARCH;
    end else begin
      lost_ticks_d = 16'd0;
      spin_phase_d = 1'b0;
      if (in_s.left_black || in_s.right_black) begin
        if (side == last_side_q) begin
          run_d = (run_q == 8'hFF) ? run_q : run_q + 8'd1;
        end else begin
          last_side_d = side;
          run_d       = 8'd0;
        end
        motion = in_s.left_black ? MS_LEFT : MS_RIGHT;
      end
    end
  end

  // Hand the classified word to the back
  always_comb begin
    cmd_o.motion      = motion;
    cmd_o.search_left = search_left_d;
    cmd_o.spin_phase  = spin_phase_d;
    cmd_o.run         = run_d;
  end

  // Advance tracking state on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lost_ticks_q  <= 16'd0;
      spin_phase_q  <= 1'b0;
      search_left_q <= 1'b0;
      last_side_q   <= SIDE_NONE;
      run_q         <= 8'd0;
    end else if (push_o) begin
      lost_ticks_q  <= lost_ticks_d;
      spin_phase_q  <= spin_phase_d;
      search_left_q <= search_left_d;
      last_side_q   <= last_side_d;
      run_q         <= run_d;
    end
  end

endmodule

### hdl/lfsc_fifo.sv
module lfsc_fifo #(
  parameter int unsigned Depth = lfsc_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lfsc_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output lfsc_pkg::cmd_t data_o
);
  import lfsc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

### hdl/lfsc_back.sv
module lfsc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lfsc_pkg::cfg_t cfg_i,
  input  logic           empty_i,
  input  lfsc_pkg::cmd_t cmd_i,
  output logic           pop_o,
  lfsc_out_if.source     out_s
);
  import lfsc_pkg::*;

  localparam logic signed [9:0] Lim = 10'(SpeedLimit);

  logic signed [9:0] straight, outer, slow, spin, ls, rs;
  logic [10:0]       corr_sum;
  logic [7:0]        diff;
  logic signed [8:0] ls_c, rs_c;
  logic              lost_frame, load;

  logic              valid_q;
  motion_e           motion_q;
  logic signed [8:0] ls_q, rs_q;
  dir_e              ldir_q, rdir_q;
  logic [7:0]        lmag_q, rmag_q;

  // Load the output word when it is empty or being taken
  assign load  = ~valid_q | out_s.ready;
  assign pop_o = load & ~empty_i;

  // Operand forms of the registers
  assign straight = {2'b00, cfg_i.straight_speed};
  assign outer    = {2'b00, cfg_i.turn_outer_speed};
  assign spin     = {2'b00, cfg_i.spin_speed};
  assign slow     = straight - {2'b00, cfg_i.search_slowdown};

  // Correction grows with the run on the same side, capped
  assign corr_sum = {3'b000, cfg_i.correction_min} + {1'b0, cmd_i.run, 2'b00}
                    + {3'b000, cmd_i.run};
  assign diff     = (corr_sum > {3'b000, cfg_i.correction_max}) ? cfg_i.correction_max
                                                                : corr_sum[7:0];

  // Wheel commands per motion state
  always_comb begin
    ls = '0;
    rs = '0;
    unique case (cmd_i.motion)
      MS_FORWARD: begin
        ls = straight;
        rs = straight;
      end
      MS_LEFT: begin
        ls = outer - {2'b00, diff};
        rs = outer;
      end
      MS_RIGHT: begin
        ls = outer;
        rs = outer - {2'b00, diff};
      end
      MS_SEARCH: begin
        ls = cmd_i.search_left ? slow : straight;
        rs = cmd_i.search_left ? straight : slow;
      end
      MS_SPIN: begin
        ls = cmd_i.spin_phase ? spin : -spin;
        rs = cmd_i.spin_phase ? -spin : spin;
      end
      default: begin
        ls = '0;
        rs = '0;
      end
    endcase
  end

  // Clamp to the speed limit
  assign ls_c = (ls > Lim) ? 9'(Lim) : (ls < -Lim) ? 9'(-Lim) : ls[8:0];
  assign rs_c = (rs > Lim) ? 9'(Lim) : (rs < -Lim) ? 9'(-Lim) : rs[8:0];
  assign lost_frame = (cmd_i.motion == MS_SEARCH) || (cmd_i.motion == MS_SPIN);

  // Hold the result word until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= ~empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      motion_q <= cmd_i.motion;
      ls_q     <= ls_c;
      rs_q     <= rs_c;
      ldir_q   <= lost_frame ? DIR_LOST : (ls_c[8] ? DIR_REV : DIR_FWD);
      rdir_q   <= lost_frame ? DIR_LOST : (rs_c[8] ? DIR_REV : DIR_FWD);
      lmag_q   <= ls_c[8] ? 8'(-ls_c) : ls_c[7:0];
      rmag_q   <= rs_c[8] ? 8'(-rs_c) : rs_c[7:0];
    end
  end

  assign out_s.valid           = valid_q;
  assign out_s.motion_state    = motion_q;
  assign out_s.left_wheel      = ls_q;
  assign out_s.right_wheel     = rs_q;
  assign out_s.left_dir_code   = ldir_q;
  assign out_s.left_magnitude  = lmag_q;
  assign out_s.right_dir_code  = rdir_q;
  assign out_s.right_magnitude = rmag_q;

endmodule

### hdl/line_follow_steering_controller.sv
// Steering controller for a two-sensor line follower. Each input word is one sensor tick
// (two line flags and an ultrasonic echo time) and yields exactly one result word: the
// motion state, the signed wheel speeds clamped to +/-150 and the motor frame direction
// codes and magnitudes. A front stage classifies the tick and updates the lost-line and
// side-tracking state in the cycle it is accepted; a two-word queue passes the classified
// tick to a back stage that works out the wheel speeds and holds them in an output
// register. One word is accepted per clock cycle while the queue has room; an accepted
// word is written into the queue and then into the output register, which holds the
// result word until it is taken. Input ready drops only once the queue has filled behind
// a stalled output. Registers are written over APB at byte address 4*index and must only
// be changed while no tick is in flight.
module line_follow_steering_controller #(
  parameter int unsigned QueueDepth = lfsc_pkg::QueueDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  lfsc_in_if.sink                    in_s,
  lfsc_out_if.source                 out_s,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lfsc_pkg::AddrW-1:0] paddr,
  input  logic [lfsc_pkg::DataW-1:0] pwdata,
  output logic [lfsc_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import lfsc_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     wr_en;
  logic     push, pop, full, empty;
  cmd_t     cmd_in, cmd_out;

  // Register file
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.straight_speed     <= 8'd100;
      cfg_q.turn_outer_speed   <= 8'd40;
      cfg_q.correction_min     <= 8'd25;
      cfg_q.correction_max     <= 8'd40;
      cfg_q.search_slowdown    <= 8'd25;
      cfg_q.spin_speed         <= 8'd35;
      cfg_q.lost_timeout_ticks <= 8'd20;
      cfg_q.obstacle_echo_us   <= 16'd706;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_STRAIGHT: cfg_q.straight_speed     <= pwdata[7:0];
        REG_OUTER:    cfg_q.turn_outer_speed   <= pwdata[7:0];
        REG_CORR_MIN: cfg_q.correction_min     <= pwdata[7:0];
        REG_CORR_MAX: cfg_q.correction_max     <= pwdata[7:0];
        REG_SEARCH:   cfg_q.search_slowdown    <= pwdata[7:0];
        REG_SPIN:     cfg_q.spin_speed         <= pwdata[7:0];
        REG_TIMEOUT:  cfg_q.lost_timeout_ticks <= pwdata[7:0];
        REG_OBSTACLE: cfg_q.obstacle_echo_us   <= pwdata[15:0];
        default:      ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_STRAIGHT: prdata = DataW'(cfg_q.straight_speed);
      REG_OUTER:    prdata = DataW'(cfg_q.turn_outer_speed);
      REG_CORR_MIN: prdata = DataW'(cfg_q.correction_min);
      REG_CORR_MAX: prdata = DataW'(cfg_q.correction_max);
      REG_SEARCH:   prdata = DataW'(cfg_q.search_slowdown);
      REG_SPIN:     prdata = DataW'(cfg_q.spin_speed);
      REG_TIMEOUT:  prdata = DataW'(cfg_q.lost_timeout_ticks);
      REG_OBSTACLE: prdata = DataW'(cfg_q.obstacle_echo_us);
      default:      prdata = '0;
    endcase
  end

  lfsc_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_s   (in_s),
    .cfg_i  (cfg_q),
    .full_i (full),
    .push_o (push),
    .cmd_o  (cmd_in)
  );

  lfsc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (cmd_out)
  );

  lfsc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .empty_i (empty),
    .cmd_i   (cmd_out),
    .pop_o   (pop),
    .out_s   (out_s)
  );

  // A stop word carries no wheel motion
  a_stop_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_s.valid && (out_s.motion_state == MS_STOP)
    |-> (out_s.left_wheel == 9'sd0) && (out_s.right_wheel == 9'sd0))
    else $error("stop word with nonzero wheel speed");

  // Lost states always send the lost direction code on both wheels
  a_lost_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_s.valid && ((out_s.motion_state == MS_SEARCH) || (out_s.motion_state == MS_SPIN))
    |-> (out_s.left_dir_code == DIR_LOST) && (out_s.right_dir_code == DIR_LOST))
    else $error("lost state without lost direction code");

  // Magnitudes never exceed the speed limit
  a_mag_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_s.valid |-> (out_s.left_magnitude <= 8'(SpeedLimit))
                    && (out_s.right_magnitude <= 8'(SpeedLimit)))
    else $error("wheel magnitude above limit");

  // Input back-pressure only follows a stalled output
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_s.ready |-> $past(out_s.valid && !out_s.ready))
    else $error("input stalled without output stall");

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import lfsc_pkg::*;

  // One sensor tick as driven on the input channel
  typedef struct packed {
    logic        left_black;
    logic        right_black;
    logic        echo_valid;
    logic [15:0] echo_us;
  } tick_t;

  // Wheel command word as it leaves the block
  typedef struct packed {
    motion_e           motion;
    logic signed [8:0] left_wheel;
    logic signed [8:0] right_wheel;
    dir_e              left_dir;
    logic [7:0]        left_mag;
    dir_e              right_dir;
    logic [7:0]        right_mag;
  } steer_cmd_t;

  logic clk_i;
  logic rst_ni;

  lfsc_in_if  in_if ();
  lfsc_out_if out_if ();

  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrW-1:0]     paddr;
  logic [DataW-1:0]     pwdata;
  logic [DataW-1:0]     prdata;
  logic                 pready;

  line_follow_steering_controller DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_s    (in_if),
    .out_s   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the register file and of the steering state
  cfg_t       steer_cfg;
  logic [15:0] lost_run;
  logic        spin_odd;
  logic        search_left;
  side_e       last_side;
  logic [7:0]  side_run;

  steer_cmd_t expected_cmds[$];
  int         fault_count;
  bit         idle_en;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("line_follow_steering_controller verification failed");
    $finish;
  end

  // Gap length: mostly short, now and then long
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Output back-pressure
  initial begin : drive_out_ready
    int stall;
    stall = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else begin
        out_if.ready <= 1'b1;
        if (idle_en && $urandom_range(0, 3) == 0) stall = idle_gap();
      end
    end
  end

  // Work out the wheel command for one tick and advance the shadow state
  function automatic steer_cmd_t predict_steering(tick_t t);
    steer_cmd_t c;
    int         ls;
    int         rs;
    int         diff;
    int         fast;
    int         slow;
    side_e      side;
    logic       lost;
    lost = 1'b0;
    if (t.echo_valid && t.echo_us != 16'd0 && t.echo_us < steer_cfg.obstacle_echo_us) begin
      c.motion = MS_STOP;
      ls       = 0;
      rs       = 0;
      lost_run = '0;
      spin_odd = 1'b0;
    end else if (t.left_black && t.right_black) begin
      if (lost_run == 16'd0) search_left = ~search_left;
      if (lost_run != 16'hFFFF) lost_run++;
      spin_odd = ~spin_odd;
      lost     = 1'b1;
      if (lost_run < {8'd0, steer_cfg.lost_timeout_ticks}) begin
        fast     = int'(steer_cfg.straight_speed);
        slow     = fast - int'(steer_cfg.search_slowdown);
        c.motion = MS_SEARCH;
        ls       = search_left ? slow : fast;
        rs       = search_left ? fast : slow;
      end else begin
        c.motion = MS_SPIN;
        ls       = spin_odd ? int'(steer_cfg.spin_speed) : -int'(steer_cfg.spin_speed);
        rs       = -ls;
      end
    end else begin
      lost_run = '0;
      spin_odd = 1'b0;
      if (t.left_black || t.right_black) begin
        side = t.left_black ? SIDE_LEFT : SIDE_RIGHT;
        if (side == last_side) begin
          if (side_run != 8'hFF) side_run++;
        end else begin
          last_side = side;
          side_run  = '0;
        end
        diff = int'(steer_cfg.correction_min) + int'(side_run) * int'(CorrStep);
        if (diff > int'(steer_cfg.correction_max)) diff = int'(steer_cfg.correction_max);
        if (side == SIDE_LEFT) begin
          c.motion = MS_LEFT;
          ls       = int'(steer_cfg.turn_outer_speed) - diff;
          rs       = int'(steer_cfg.turn_outer_speed);
        end else begin
          c.motion = MS_RIGHT;
          ls       = int'(steer_cfg.turn_outer_speed);
          rs       = int'(steer_cfg.turn_outer_speed) - diff;
        end
      end else begin
        c.motion = MS_FORWARD;
        ls       = int'(steer_cfg.straight_speed);
        rs       = ls;
      end
    end
    // Clamp to the wheel limit
    if (ls > int'(SpeedLimit)) ls = SpeedLimit;
    if (ls < -int'(SpeedLimit)) ls = -int'(SpeedLimit);
    if (rs > int'(SpeedLimit)) rs = SpeedLimit;
    if (rs < -int'(SpeedLimit)) rs = -int'(SpeedLimit);
    c.left_wheel  = ls[8:0];
    c.right_wheel = rs[8:0];
    c.left_dir    = lost ? DIR_LOST : (ls < 0 ? DIR_REV : DIR_FWD);
    c.right_dir   = lost ? DIR_LOST : (rs < 0 ? DIR_REV : DIR_FWD);
    c.left_mag    = ls < 0 ? 8'(-ls) : 8'(ls);
    c.right_mag   = rs < 0 ? 8'(-rs) : 8'(rs);
    return c;
  endfunction

  task automatic report_fault(string msg);
    if (fault_count < 10) $display("%s", msg);
    fault_count++;
  endtask

  // Compare each accepted word with the oldest expectation
  always @(posedge clk_i) begin : check_results
    steer_cmd_t got;
    steer_cmd_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.motion      = motion_e'(out_if.motion_state);
      got.left_wheel  = out_if.left_wheel;
      got.right_wheel = out_if.right_wheel;
      got.left_dir    = dir_e'(out_if.left_dir_code);
      got.left_mag    = out_if.left_magnitude;
      got.right_dir   = dir_e'(out_if.right_dir_code);
      got.right_mag   = out_if.right_magnitude;
      if (expected_cmds.size() == 0) begin
        report_fault($sformatf("unexpected result word at %0t: state %0d L %0d R %0d",
                               $realtime, got.motion, got.left_wheel, got.right_wheel));
      end else begin
        want = expected_cmds.pop_front();
        if (got !== want) begin
          report_fault({
            $sformatf("mismatch at %0t: exp state %0d L %0d/%0d/%0d R %0d/%0d/%0d, ",
                      $realtime, want.motion, want.left_wheel, want.left_dir,
                      want.left_mag, want.right_wheel, want.right_dir, want.right_mag),
            $sformatf("got state %0d L %0d/%0d/%0d R %0d/%0d/%0d",
                      got.motion, got.left_wheel, got.left_dir, got.left_mag,
                      got.right_wheel, got.right_dir, got.right_mag)});
        end
      end
    end
  end

  // Send one tick, hold it until accepted, then predict its word
  task automatic send_tick(logic lb, logic rb, logic ev, logic [15:0] echo);
    tick_t t;
    int    gap;
    t   = '{left_black: lb, right_black: rb, echo_valid: ev, echo_us: echo};
    gap = idle_en ? idle_gap() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.left_black  <= t.left_black;
    in_if.right_black <= t.right_black;
    in_if.echo_valid  <= t.echo_valid;
    in_if.echo_us     <= t.echo_us;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    expected_cmds.push_back(predict_steering(t));
  endtask

  // Drop valid and let every outstanding word come back
  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle
  task automatic write_reg(reg_idx_e idx, logic [15:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_STRAIGHT: steer_cfg.straight_speed     = value[7:0];
      REG_OUTER:    steer_cfg.turn_outer_speed   = value[7:0];
      REG_CORR_MIN: steer_cfg.correction_min     = value[7:0];
      REG_CORR_MAX: steer_cfg.correction_max     = value[7:0];
      REG_SEARCH:   steer_cfg.search_slowdown    = value[7:0];
      REG_SPIN:     steer_cfg.spin_speed         = value[7:0];
      REG_TIMEOUT:  steer_cfg.lost_timeout_ticks = value[7:0];
      REG_OBSTACLE: steer_cfg.obstacle_echo_us   = value;
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_all_regs(int straight, int outer, int cmin, int cmax, int slow,
                                int spin, int timeout, int obstacle);
    write_reg(REG_STRAIGHT, 16'(straight));
    write_reg(REG_OUTER,    16'(outer));
    write_reg(REG_CORR_MIN, 16'(cmin));
    write_reg(REG_CORR_MAX, 16'(cmax));
    write_reg(REG_SEARCH,   16'(slow));
    write_reg(REG_SPIN,     16'(spin));
    write_reg(REG_TIMEOUT,  16'(timeout));
    write_reg(REG_OBSTACLE, 16'(obstacle));
  endtask

  // Reset settings: straight, steering, obstacle edges and a short lost run
  task automatic test_reset_settings();
    send_tick(1'b0, 1'b0, 1'b0, 16'd0);
    send_tick(1'b1, 1'b0, 1'b0, 16'd0);
    send_tick(1'b1, 1'b0, 1'b0, 16'd0);
    send_tick(1'b1, 1'b0, 1'b0, 16'd0);
    send_tick(1'b0, 1'b1, 1'b0, 16'd0);
    send_tick(1'b0, 1'b1, 1'b0, 16'd0);
    send_tick(1'b0, 1'b0, 1'b0, 16'd0);
    send_tick(1'b0, 1'b0, 1'b1, 16'd1);
    send_tick(1'b1, 1'b1, 1'b1, 16'd705);
    send_tick(1'b0, 1'b1, 1'b1, 16'd706);
    send_tick(1'b1, 1'b0, 1'b1, 16'd0);
    send_tick(1'b0, 1'b0, 1'b0, 16'd1);
    repeat (3) send_tick(1'b1, 1'b1, 1'b0, 16'hFFFF);
    send_tick(1'b0, 1'b0, 1'b0, 16'd0);
    drain();
  endtask

  // Register extremes: negative speeds down to the limit, instant spin, threshold edges
  task automatic test_register_extremes();
    write_all_regs(0, 0, 150, 150, 150, 150, 1, 65535);
    repeat (4) send_tick(1'b1, 1'b1, 1'b0, 16'd0);
    send_tick(1'b1, 1'b0, 1'b0, 16'd0);
    send_tick(1'b1, 1'b0, 1'b0, 16'd0);
    send_tick(1'b0, 1'b1, 1'b0, 16'd0);
    send_tick(1'b0, 1'b0, 1'b1, 16'd65534);
    send_tick(1'b0, 1'b0, 1'b1, 16'd65535);
    send_tick(1'b0, 1'b0, 1'b0, 16'd0);
    drain();
    write_all_regs(150, 150, 0, 0, 0, 0, 255, 0);
    repeat (3) send_tick(1'b1, 1'b1, 1'b0, 16'd0);
    send_tick(1'b1, 1'b0, 1'b0, 16'd0);
    send_tick(1'b0, 1'b1, 1'b1, 16'd1);
    send_tick(1'b0, 1'b0, 1'b1, 16'd1);
    drain();
  endtask

  // Long run on one side: the run counter must hold at its top value
  task automatic test_side_run_hold();
    write_all_regs(100, 150, 0, 150, 25, 35, 20, 706);
    repeat (300) send_tick(1'b1, 1'b0, 1'b0, 16'd0);
    send_tick(1'b0, 1'b1, 1'b0, 16'd0);
    send_tick(1'b1, 1'b0, 1'b0, 16'd0);
    drain();
  endtask

  // Long lost run at the largest timeout: search up to the timeout, then alternating spin
  task automatic test_long_lost_run();
    idle_en = 1'b0;
    write_all_regs(100, 40, 25, 40, 25, 35, 255, 706);
    repeat (300) send_tick(1'b1, 1'b1, 1'b0, 16'd0);
    send_tick(1'b0, 1'b0, 1'b0, 16'd0);
    repeat (3) send_tick(1'b1, 1'b1, 1'b0, 16'd0);
    drain();
    idle_en = 1'b1;
  endtask

  function automatic int pick_level(int lo, int hi);
    case ($urandom_range(0, 3))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  // Random tick on the given line pattern, with an echo that stops or not
  task automatic send_random_tick(logic lb, logic rb, bit want_stop);
    int thr;
    int r;
    thr = int'(steer_cfg.obstacle_echo_us);
    r   = $urandom_range(0, 7);
    if (want_stop && thr > 1)
      send_tick(lb, rb, 1'b1, 16'($urandom_range(1, thr - 1)));
    else if (r == 0)
      send_tick(lb, rb, 1'b1, 16'd0);
    else if (r < 4)
      send_tick(lb, rb, 1'b0, 16'($urandom_range(0, 65535)));
    else
      send_tick(lb, rb, 1'b1, 16'($urandom_range(thr, 65535)));
  endtask

  // Random settings, then episodes of straight, steering, lost and obstacle ticks
  task automatic test_random_traffic();
    int   sent;
    int   len;
    int   kind;
    logic lb;
    logic rb;
    for (int phase = 0; phase < 8; phase++) begin
      idle_en = (phase % 4 != 1);
      write_all_regs(pick_level(0, 150), pick_level(0, 150), pick_level(0, 150),
                     pick_level(0, 150), pick_level(0, 150), pick_level(0, 150),
                     ($urandom_range(0, 3) == 0) ? pick_level(1, 255) : $urandom_range(1, 40),
                     ($urandom_range(0, 1) == 0) ? pick_level(0, 65535) :
                                                   $urandom_range(100, 2000));
      sent = 0;
      while (sent < 175) begin
        kind = $urandom_range(0, 9);
        lb   = (kind inside {[2:3]}) || (kind inside {[6:8]});
        rb   = (kind inside {[4:5]}) || (kind inside {[6:8]});
        if (kind == 9) begin
          lb = 1'($urandom_range(0, 1));
          rb = 1'($urandom_range(0, 1));
        end
        if (kind inside {[6:8]})
          len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
        else
          len = $urandom_range(1, 6);
        repeat (len) begin
          send_random_tick(lb, rb, kind == 9 || $urandom_range(0, 19) == 0);
          sent++;
        end
      end
      drain();
    end
  endtask

  // Main sequence
  initial begin
    fault_count = 0;
    idle_en     = 1'b1;
    steer_cfg   = '{straight_speed: 8'd100, turn_outer_speed: 8'd40,
                    correction_min: 8'd25, correction_max: 8'd40,
                    search_slowdown: 8'd25, spin_speed: 8'd35,
                    lost_timeout_ticks: 8'd20, obstacle_echo_us: 16'd706};
    lost_run    = '0;
    spin_odd    = 1'b0;
    search_left = 1'b0;
    last_side   = SIDE_NONE;
    side_run    = '0;

    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.left_black  <= 1'b0;
    in_if.right_black <= 1'b0;
    in_if.echo_valid  <= 1'b0;
    in_if.echo_us     <= '0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_reset_settings();
    test_register_extremes();
    test_side_run_hold();
    test_long_lost_run();
    test_random_traffic();
    drain();

    if (fault_count == 0) begin
      $display("line_follow_steering_controller verification clean");
    end else begin
      $display("line_follow_steering_controller verification failed");
    end
    $finish;
  end

endmodule

### files.f
hdl/lfsc_pkg.sv
hdl/lfsc_in_if.sv
hdl/lfsc_out_if.sv
hdl/lfsc_front.sv
hdl/lfsc_fifo.sv
hdl/lfsc_back.sv
hdl/line_follow_steering_controller.sv
test/tb_top.sv
